### rtl/vacr_pkg.sv
package vacr_pkg;

  localparam int unsigned AddrW  = 18;
  localparam int unsigned VAddrW = 16;
  localparam int unsigned DataW  = 16;
  localparam int unsigned BaseW  = 12;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned Depth  = 16;

  localparam logic [1:0] MODE_XLATE   = 2'd0;
  localparam logic [1:0] MODE_WR_DESC = 2'd1;
  localparam logic [1:0] MODE_WR_REL  = 2'd2;

  localparam logic [AddrW-1:0] IO_PAGE     = 18'o760000;
  localparam logic [AddrW-1:0] CPU_LO      = 18'o777700;
  localparam logic [AddrW-1:0] CPU_HI      = 18'o777717;
  localparam logic [AddrW-1:0] KPAR_LO     = 18'o772300;
  localparam logic [AddrW-1:0] KPAR_HI     = 18'o772377;
  localparam logic [AddrW-1:0] MMR_LO      = 18'o777570;
  localparam logic [AddrW-1:0] MMR_HI      = 18'o777577;
  localparam logic [AddrW-1:0] UPAR_LO     = 18'o777600;
  localparam logic [AddrW-1:0] UPAR_HI     = 18'o777677;
  localparam logic [AddrW-1:0] PSW_ADDR    = 18'o777776;

  localparam int unsigned PdrReadBit = 1;
  localparam int unsigned PdrDownBit = 3;

  typedef struct packed {
    logic             desc_we;
    logic             rel_we;
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic [DataW-1:0] pdr;
    logic [BaseW-1:0] par;
  } tbl_rd_t;

  typedef struct packed {
    logic             allowed;
    logic [AddrW-1:0] pa;
  } res_t;

endpackage

### rtl/virtual_address_relocation_check_top.sv
// A result passes the input register and then the result register, where out_valid marks it.
// Throughput: one transaction per cycle unless out_stall holds the output; an input register,
// one pass of table read, limit compare and base add, then the result register.
// Table writes take effect for the transaction that follows.
// Reset: asynchronous active low; clears both page tables, relocation enable
// and all valid flags.
module virtual_address_relocation_check_top
  import vacr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data_i,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       mode_i,
  input  logic [AddrW-1:0] address_i,
  input  logic             is_physical_i,
  input  logic             user_space_i,
  input  logic [IdxW-1:0]  entry_index_i,
  input  logic [DataW-1:0] entry_data_i,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             allowed_o,
  output logic [AddrW-1:0] physical_address_o
);

  logic             reloc_en_q;
  logic             s1_valid_q;
  logic [1:0]       mode_q;
  logic [AddrW-1:0] addr_q;
  logic             phys_q;
  logic             user_q;
  logic [IdxW-1:0]  idx_q;
  logic [DataW-1:0] data_q;
  logic             out_valid_q;
  res_t             res_d;
  res_t             res_q;
  logic             out_ready;
  logic             adv;
  logic             accept;
  tbl_wr_t          tbl_wr;
  tbl_rd_t          tbl_rd;
  logic [IdxW-1:0]  page;

  assign cfg_ready = 1'b1;
  assign out_ready = !out_valid_q || !out_stall;
  assign adv       = s1_valid_q && out_ready;
  assign in_stall  = s1_valid_q && !out_ready;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reloc_en_q <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      reloc_en_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      addr_q <= address_i;
      phys_q <= is_physical_i;
      user_q <= user_space_i;
      idx_q  <= entry_index_i;
      data_q <= entry_data_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign tbl_wr.desc_we = adv && (mode_q == MODE_WR_DESC);
  assign tbl_wr.rel_we  = adv && (mode_q == MODE_WR_REL);
  assign tbl_wr.idx     = idx_q;
  assign tbl_wr.data    = data_q;

  vacr_tables u_tables (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (tbl_wr),
    .rd_idx_i (page),
    .rd_o     (tbl_rd)
  );

  vacr_xlate u_xlate (
    .reloc_en_i    (reloc_en_q),
    .mode_i        (mode_q),
    .address_i     (addr_q),
    .is_physical_i (phys_q),
    .user_space_i  (user_q),
    .page_o        (page),
    .tbl_i         (tbl_rd),
    .res_o         (res_d)
  );

  assign out_valid          = out_valid_q;
  assign allowed_o          = res_q.allowed;
  assign physical_address_o = res_q.pa;

endmodule

### rtl/vacr_tables.sv
module vacr_tables
  import vacr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tbl_wr_t         wr_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output tbl_rd_t         rd_o
);

  logic [DataW-1:0] desc_q [Depth];
  logic [BaseW-1:0] rel_q  [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        desc_q[i] <= '0;
        rel_q[i]  <= '0;
      end
    end else begin
      if (wr_i.desc_we) begin
        desc_q[wr_i.idx] <= wr_i.data;
      end
      if (wr_i.rel_we) begin
        rel_q[wr_i.idx] <= wr_i.data[BaseW-1:0];
      end
    end
  end

  assign rd_o.pdr = desc_q[rd_idx_i];
  assign rd_o.par = rel_q[rd_idx_i];

endmodule

### rtl/vacr_xlate.sv
module vacr_xlate
  import vacr_pkg::*;
(
  input  logic             reloc_en_i,
  input  logic [1:0]       mode_i,
  input  logic [AddrW-1:0] address_i,
  input  logic             is_physical_i,
  input  logic             user_space_i,
  output logic [IdxW-1:0]  page_o,
  input  tbl_rd_t          tbl_i,
  output res_t             res_o
);

  logic [VAddrW-1:0] va;
  logic [6:0]        blok;
  logic [6:0]        len;
  logic              desc_ok;
  logic [AddrW-1:0]  a;
  logic              io_ok;

  assign va      = address_i[VAddrW-1:0];
  assign page_o  = {user_space_i, va[15:13]};
  assign blok    = va[12:6];
  assign len     = tbl_i.pdr[14:8];
  assign desc_ok = tbl_i.pdr[PdrReadBit] &&
                   (tbl_i.pdr[PdrDownBit] ? (blok >= len) : (blok <= len));

  always_comb begin
    if (is_physical_i) begin
      a = address_i;
    end else if (!reloc_en_i) begin
      a = (va[15:13] == 3'b111) ? {2'b11, va} : {2'b00, va};
    end else begin
      a = {5'd0, va[12:0]} + {tbl_i.par, 6'd0};
    end
  end

  assign io_ok = (a < IO_PAGE) ||
                 (a >= CPU_LO && a <= CPU_HI) ||
                 (a >= KPAR_LO && a <= KPAR_HI) ||
                 (a >= MMR_LO && a <= MMR_HI) ||
                 (a >= UPAR_LO && a <= UPAR_HI) ||
                 (a == PSW_ADDR);

  always_comb begin
    res_o.allowed = 1'b1;
    res_o.pa      = '0;
    if (mode_i == MODE_XLATE) begin
      if (!is_physical_i && reloc_en_i && !desc_ok) begin
        res_o.allowed = 1'b0;
        res_o.pa      = '0;
      end else begin
        res_o.allowed = io_ok;
        res_o.pa      = a;
      end
    end
  end

endmodule
